// ===== rtl/core/utf8_word_tokenizer_defines.svh =====
// Assertion macros for the tokenizer core.
`ifndef UTF8_WORD_TOKENIZER_DEFINES_SVH
`define UTF8_WORD_TOKENIZER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define UWT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tokenizer assertion failed");
`define UWT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("tokenizer assertion failed");
`else
`define UWT_ASSERT(lbl, clk, rst_n, prop)
`define UWT_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== rtl/core/uwt_pkg.sv =====
package uwt_pkg;

    localparam int MAX_EV  = 4;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    localparam logic [1:0] KIND_LETTER = 2'd0;
    localparam logic [1:0] KIND_WORD   = 2'd1;
    localparam logic [1:0] KIND_BREAK  = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_line;
    } t_in_word;

    typedef struct packed {
        logic [1:0] event_kind;
        logic [7:0] letter;
        logic       last_of_run;
    } t_out_word;

    typedef struct packed {
        logic [2:0]              count;
        logic [MAX_EV-1:0][1:0]  kinds;
        logic [7:0]              letter;
    } t_bundle;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

// ===== rtl/core/uwt_front.sv =====
module uwt_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  uwt_pkg::t_in_word i_in_word,
    output logic              o_q_push,
    output uwt_pkg::t_bundle  o_bundle
);
    import uwt_pkg::*;

    localparam logic [7:0] BYTE_FOLD   = 8'hC3;
    localparam logic [7:0] BYTE_SKIP2  = 8'hC2;
    localparam logic [7:0] BYTE_SKIP3  = 8'hE2;
    localparam logic [7:0] BYTE_SPACE  = 8'h20;
    localparam logic [7:0] BYTE_HYPHEN = 8'h2D;

    function automatic logic [7:0] fold_capital(input logic [7:0] b);
        case (b)
            8'h91:   fold_capital = 8'hB1;
            8'h81:   fold_capital = 8'hA1;
            8'h84:   fold_capital = 8'hA4;
            8'h89:   fold_capital = 8'hA9;
            8'h8B:   fold_capital = 8'hAB;
            8'h8D:   fold_capital = 8'hAD;
            8'h8F:   fold_capital = 8'hAF;
            8'h93:   fold_capital = 8'hB3;
            8'h96:   fold_capital = 8'hB6;
            8'h9A:   fold_capital = 8'hBA;
            8'h9C:   fold_capital = 8'hBC;
            default: fold_capital = b;
        endcase
    endfunction

    function automatic logic is_punct(input logic [7:0] b);
        case (b)
            8'h2E, 8'h2C, 8'h2F, 8'h3F, 8'h21, 8'h3A, 8'h3B,
            8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h28, 8'h29, 8'h3D,
            8'h25, 8'h5E, 8'h24, 8'h23, 8'h40, 8'h22, 8'h7E,
            8'h60, 8'h3C, 8'h3E, 8'h5F, 8'h2A, 8'h26, 8'h2B,
            8'h5C, 8'h7C, 8'h09: is_punct = 1'b1;
            default:             is_punct = 1'b0;
        endcase
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        if (b >= 8'h41 && b <= 8'h5A) begin
            to_lower = b + 8'h20;
        end else begin
            to_lower = b;
        end
    endfunction

    logic       r_word_open, n_word_open;
    logic [1:0] r_skip_left, n_skip_left;
    logic       r_fold_pending, n_fold_pending;
    t_bundle    bnd;
    logic [7:0] b;

    always_comb begin
        n_word_open    = r_word_open;
        n_skip_left    = r_skip_left;
        n_fold_pending = r_fold_pending;
        bnd            = '0;
        b              = i_in_word.data_byte;
        if (i_in_word.has_byte) begin
            if (r_skip_left != 2'd0) begin
                n_skip_left = r_skip_left - 2'd1;
            end else if (r_fold_pending) begin
                bnd.kinds[0]   = KIND_LETTER;
                bnd.letter     = fold_capital(b);
                bnd.count      = 3'd1;
                n_fold_pending = 1'b0;
            end else if (b == BYTE_FOLD) begin
                bnd.kinds[0]   = KIND_LETTER;
                bnd.letter     = b;
                bnd.count      = 3'd1;
                n_word_open    = 1'b1;
                n_fold_pending = 1'b1;
            end else if (b == BYTE_SKIP2 || b == BYTE_SKIP3) begin
                if (r_word_open) begin
                    bnd.kinds[0] = KIND_WORD;
                    bnd.kinds[1] = KIND_BREAK;
                    bnd.count    = 3'd2;
                    n_word_open  = 1'b0;
                end
                n_skip_left = (b == BYTE_SKIP2) ? 2'd1 : 2'd2;
            end else if (b == BYTE_SPACE) begin
                if (r_word_open) begin
                    bnd.kinds[0] = KIND_WORD;
                    bnd.count    = 3'd1;
                    n_word_open  = 1'b0;
                end
            end else if (b == BYTE_HYPHEN) begin
                if (r_word_open) begin
                    bnd.kinds[0] = KIND_LETTER;
                    bnd.letter   = b;
                    bnd.count    = 3'd1;
                end
            end else if (is_punct(b)) begin
                if (r_word_open) begin
                    bnd.kinds[0] = KIND_WORD;
                    bnd.kinds[1] = KIND_BREAK;
                    bnd.count    = 3'd2;
                    n_word_open  = 1'b0;
                end
            end else begin
                bnd.kinds[0] = KIND_LETTER;
                bnd.letter   = to_lower(b);
                bnd.count    = 3'd1;
                n_word_open  = 1'b1;
            end
        end
        if (i_in_word.end_of_line) begin
            if (n_word_open) begin
                bnd.kinds[bnd.count[1:0]] = KIND_WORD;
                bnd.count                 = bnd.count + 3'd1;
            end
            bnd.kinds[bnd.count[1:0]] = KIND_BREAK;
            bnd.count                 = bnd.count + 3'd1;
            n_word_open               = 1'b0;
            n_skip_left               = 2'd0;
            n_fold_pending            = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_open    <= 1'b0;
            r_skip_left    <= 2'd0;
            r_fold_pending <= 1'b0;
        end else if (i_accept) begin
            r_word_open    <= n_word_open;
            r_skip_left    <= n_skip_left;
            r_fold_pending <= n_fold_pending;
        end
    end

    assign o_q_push = i_accept && (bnd.count != 3'd0);
    assign o_bundle = bnd;

    `include "utf8_word_tokenizer_defines.svh"

    `UWT_ASSERT(a_skip_excludes_fold, i_clk, i_rst_n, (r_skip_left != 2'd0) |-> !r_fold_pending)
    `UWT_ASSERT(a_fold_in_word, i_clk, i_rst_n, r_fold_pending |-> r_word_open)

endmodule

// ===== rtl/core/uwt_queue.sv =====
module uwt_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  uwt_pkg::t_bundle   i_bundle,
    input  logic               i_pop,
    output uwt_pkg::t_q_status o_status,
    output uwt_pkg::t_bundle   o_head
);
    import uwt_pkg::*;

    t_bundle         r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_AW:0]   r_count;
    logic            do_push;
    logic            do_pop;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_head         = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + Q_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + (Q_AW+1)'(1);
                2'b01:   r_count <= r_count - (Q_AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    `include "utf8_word_tokenizer_defines.svh"

    `UWT_ASSERT(a_no_push_full, i_clk, i_rst_n, !(i_push && o_status.full))
    `UWT_ASSERT(a_ptr_gap, i_clk, i_rst_n, (r_wr_ptr - r_rd_ptr) == r_count[Q_AW-1:0])

endmodule

// ===== rtl/core/uwt_back.sv =====
module uwt_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  uwt_pkg::t_q_status i_q_status,
    input  uwt_pkg::t_bundle   i_head,
    output logic               o_q_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output uwt_pkg::t_out_word o_out_word
);
    import uwt_pkg::*;

    logic [1:0] r_idx;
    logic       r_out_vld;
    t_out_word  r_out;
    logic       load;
    logic       last;
    logic [1:0] kind;

    assign load    = (!r_out_vld || i_pop) && !i_q_status.empty;
    assign kind    = i_head.kinds[r_idx];
    assign last    = ({1'b0, r_idx} + 3'd1) == i_head.count;
    assign o_q_pop = load && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= 2'd0;
            r_out_vld <= 1'b0;
        end else begin
            if (load) begin
                r_out_vld <= 1'b1;
                r_idx     <= last ? 2'd0 : r_idx + 2'd1;
            end else if (i_pop) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.event_kind  <= kind;
            r_out.letter      <= (kind == KIND_LETTER) ? i_head.letter : 8'd0;
            r_out.last_of_run <= last;
        end
    end

    assign o_empty    = !r_out_vld;
    assign o_out_word = r_out;

    `include "utf8_word_tokenizer_defines.svh"

    `UWT_ASSERT(a_mid_bundle_head, i_clk, i_rst_n, (r_idx != 2'd0) |-> !i_q_status.empty)
    `UWT_ASSERT(a_idx_in_bundle, i_clk, i_rst_n, !i_q_status.empty |-> ({1'b0, r_idx} < i_head.count))

endmodule

// ===== rtl/core/utf8_word_tokenizer.sv =====
// UTF-8 word tokenizer. Feed the bytes of a text line, one word per push, and pop letter,
// word-end and chain-break events in order; last_of_run marks the final event of each
// pushed word. A push is taken every cycle while full is low. The front classifies the
// byte and updates the tokenizer state in the cycle it is taken, then drops the events it
// causes (up to three) as one bundle into a four-entry queue; pushes that cause no event
// never enter the queue. The back sends one event per cycle from that queue while pop is
// high or its output is empty, through an output register; full rises only when the
// queue is holding four bundles. An event passes the queue, then the output register.
// There is no startup sweep: the block is ready right after reset.
module utf8_word_tokenizer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  uwt_pkg::t_in_word  i_in_word,
    output logic               empty,
    input  logic               pop,
    output uwt_pkg::t_out_word o_out_word
);
    import uwt_pkg::*;

    logic      q_push;
    logic      q_pop;
    t_bundle   bundle_in;
    t_bundle   head;
    t_q_status q_status;
    logic      accept;

    assign accept = push && !q_status.full;
    assign full   = q_status.full;

    uwt_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_in_word (i_in_word),
        .o_q_push  (q_push),
        .o_bundle  (bundle_in)
    );

    uwt_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_bundle (bundle_in),
        .i_pop    (q_pop),
        .o_status (q_status),
        .o_head   (head)
    );

    uwt_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_head     (head),
        .o_q_pop    (q_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_out_word (o_out_word)
    );

endmodule

// ===== verif/utf8_word_tokenizer_tb.sv =====
`timescale 1ns / 100ps

module utf8_word_tokenizer_tb;

    import uwt_pkg::*;

    localparam int         RANDOM_ITEMS = 280;
    localparam int         CALM_TAIL    = 40;
    localparam int         DRAIN_CYCLES = 20;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         MAX_PRINTS   = 30;
    localparam logic [7:0] LEAD_FOLD    = 8'hC3;
    localparam logic [7:0] LEAD_SKIP2   = 8'hC2;
    localparam logic [7:0] LEAD_SKIP3   = 8'hE2;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_DASH    = 8'h2D;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    localparam logic [7:0] PUNCT_BYTES [31] = '{
        8'h2E, 8'h2C, 8'h2F, 8'h3F, 8'h21, 8'h3A, 8'h3B, 8'h7B, 8'h7D, 8'h5B, 8'h5D,
        8'h28, 8'h29, 8'h3D, 8'h25, 8'h5E, 8'h24, 8'h23, 8'h40, 8'h22, 8'h7E, 8'h60,
        8'h3C, 8'h3E, 8'h5F, 8'h2A, 8'h26, 8'h2B, 8'h5C, 8'h7C, 8'h09
    };
    localparam logic [7:0] CAPITAL_TAILS [11] = '{
        8'h91, 8'h81, 8'h84, 8'h89, 8'h8B, 8'h8D, 8'h8F, 8'h93, 8'h96, 8'h9A, 8'h9C
    };

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push    = 1'b0;
    logic      pop     = 1'b0;
    t_in_word  i_in_word = '0;
    logic      full;
    logic      empty;
    t_out_word o_out_word;

    t_in_word  line_items[$];
    t_out_word expected_events[$];

    logic       tok_word_open    = 1'b0;
    logic [1:0] tok_skip_left    = 2'd0;
    logic       tok_fold_pending = 1'b0;

    int   ignored_cnt  = 0;
    int   mismatch_cnt = 0;
    int   cycle_cnt    = 0;
    int   feed_gap     = 0;
    int   drain_gap    = 0;
    logic feed_idle_on  = 1'b1;
    logic drain_idle_on = 1'b1;

    utf8_word_tokenizer DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_word  (i_in_word),
        .empty      (empty),
        .pop        (pop),
        .o_out_word (o_out_word)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_out_word make_event(input logic [1:0] kind, input logic [7:0] ch);
        t_out_word ev;
        ev.event_kind  = kind;
        ev.letter      = (kind == KIND_LETTER) ? ch : 8'h00;
        ev.last_of_run = 1'b0;
        return ev;
    endfunction

    function automatic logic is_punct(input logic [7:0] b);
        logic hit;
        hit = 1'b0;
        foreach (PUNCT_BYTES[i])
            if (PUNCT_BYTES[i] == b)
                hit = 1'b1;
        return hit;
    endfunction

    task automatic tokenize(input t_in_word w);
        t_out_word  evs[$];
        logic [7:0] b;
        b = w.data_byte;
        if (w.has_byte) begin
            if (tok_skip_left != 2'd0) begin
                tok_skip_left = tok_skip_left - 2'd1;
            end else if (tok_fold_pending) begin
                foreach (CAPITAL_TAILS[i])
                    if (CAPITAL_TAILS[i] == w.data_byte)
                        b = w.data_byte + CASE_OFFSET;
                evs.push_back(make_event(KIND_LETTER, b));
                tok_fold_pending = 1'b0;
            end else if (b == LEAD_FOLD) begin
                evs.push_back(make_event(KIND_LETTER, b));
                tok_word_open    = 1'b1;
                tok_fold_pending = 1'b1;
            end else if (b == LEAD_SKIP2 || b == LEAD_SKIP3 || is_punct(b)) begin
                if (tok_word_open) begin
                    evs.push_back(make_event(KIND_WORD, 8'h00));
                    evs.push_back(make_event(KIND_BREAK, 8'h00));
                    tok_word_open = 1'b0;
                end
                if (b == LEAD_SKIP2)
                    tok_skip_left = 2'd1;
                else if (b == LEAD_SKIP3)
                    tok_skip_left = 2'd2;
            end else if (b == CHAR_SPACE) begin
                if (tok_word_open) begin
                    evs.push_back(make_event(KIND_WORD, 8'h00));
                    tok_word_open = 1'b0;
                end
            end else if (b == CHAR_DASH) begin
                if (tok_word_open)
                    evs.push_back(make_event(KIND_LETTER, b));
            end else begin
                if (b >= "A" && b <= "Z")
                    b = b + CASE_OFFSET;
                evs.push_back(make_event(KIND_LETTER, b));
                tok_word_open = 1'b1;
            end
        end
        if (w.end_of_line) begin
            if (tok_word_open)
                evs.push_back(make_event(KIND_WORD, 8'h00));
            evs.push_back(make_event(KIND_BREAK, 8'h00));
            tok_word_open    = 1'b0;
            tok_skip_left    = 2'd0;
            tok_fold_pending = 1'b0;
        end
        if (evs.size() != 0)
            evs[evs.size() - 1].last_of_run = 1'b1;
        foreach (evs[i])
            expected_events.push_back(evs[i]);
    endtask

    task automatic report_mismatch(input string what, input int want, input int got);
        if (mismatch_cnt < MAX_PRINTS)
            $display("%0t mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
        mismatch_cnt++;
    endtask

    task automatic check_event(input t_out_word got);
        t_out_word want;
        if (expected_events.size() == 0) begin
            report_mismatch("unexpected event", 0, got);
            return;
        end
        want = expected_events.pop_front();
        if (got.event_kind != want.event_kind)
            report_mismatch("event_kind", want.event_kind, got.event_kind);
        if (got.letter != want.letter)
            report_mismatch("letter", want.letter, got.letter);
        if (got.last_of_run != want.last_of_run)
            report_mismatch("last_of_run", want.last_of_run, got.last_of_run);
    endtask

    task automatic add_item(input logic [7:0] b, input logic has, input logic eol);
        t_in_word w;
        w.data_byte   = b;
        w.has_byte    = has;
        w.end_of_line = eol;
        line_items.push_back(w);
        if (!has && !eol)
            ignored_cnt++;
    endtask

    task automatic add_word();
        int len;
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
            case ($urandom_range(0, 9))
                0: begin
                    add_item(LEAD_FOLD, 1'b1, 1'b0);
                    if ($urandom_range(0, 2) != 0)
                        add_item(CAPITAL_TAILS[$urandom_range(0, 10)], 1'b1, 1'b0);
                    else
                        add_item(8'($urandom_range(8'h80, 8'hBF)), 1'b1, 1'b0);
                end
                1: begin
                    add_item(CHAR_DASH, 1'b1, 1'b0);
                end
                2, 3: begin
                    add_item(8'($urandom_range("A", "Z")), 1'b1, 1'b0);
                end
                4: begin
                    add_item(8'($urandom_range(8'h30, 8'h39)), 1'b1, 1'b0);
                end
                default: begin
                    add_item(8'($urandom_range("a", "z")), 1'b1, 1'b0);
                end
            endcase
        end
    endtask

    task automatic add_separator();
        case ($urandom_range(0, 7))
            0: begin
                add_item(PUNCT_BYTES[$urandom_range(0, 30)], 1'b1, 1'b0);
            end
            1: begin
                add_item(PUNCT_BYTES[$urandom_range(0, 30)], 1'b1, 1'b0);
                add_item(CHAR_SPACE, 1'b1, 1'b0);
            end
            2: begin
                add_item(LEAD_SKIP2, 1'b1, 1'b0);
                add_item(8'($urandom_range(8'h80, 8'hBF)), 1'b1, 1'b0);
            end
            3: begin
                add_item(LEAD_SKIP3, 1'b1, 1'b0);
                add_item(8'($urandom_range(8'h80, 8'hBF)), 1'b1, 1'b0);
                add_item(8'($urandom_range(8'h80, 8'hBF)), 1'b1, 1'b0);
            end
            4: begin
                add_item(CHAR_SPACE, 1'b1, 1'b0);
                add_item(CHAR_SPACE, 1'b1, 1'b0);
            end
            default: begin
                add_item(CHAR_SPACE, 1'b1, 1'b0);
            end
        endcase
    endtask

    task automatic add_line();
        int words;
        words = $urandom_range(1, 5);
        for (int k = 0; k < words; k++) begin
            add_word();
            if (k != words - 1 || $urandom_range(0, 1) == 0)
                add_separator();
        end
        case ($urandom_range(0, 5))
            0: add_item(LEAD_FOLD, 1'b1, 1'b1);
            1: add_item(LEAD_SKIP3, 1'b1, 1'b1);
            2, 3: add_item(8'($urandom), 1'b0, 1'b1);
            default: line_items[line_items.size() - 1].end_of_line = 1'b1;
        endcase
    endtask

    task automatic add_noise();
        int n;
        n = $urandom_range(1, 10);
        repeat (n) begin
            add_item(8'($urandom), $urandom_range(0, 7) != 0, $urandom_range(0, 7) == 0);
        end
    endtask

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                tokenize(line_items.pop_front());
                if (feed_idle_on && line_items.size() > CALM_TAIL && $urandom_range(0, 5) == 0)
                    feed_gap = $urandom_range(1, 12);
            end
            if ($urandom_range(0, 63) == 0)
                feed_idle_on = !feed_idle_on;
            if (feed_gap != 0) begin
                feed_gap--;
                push <= 1'b0;
            end else if (line_items.size() != 0) begin
                push      <= 1'b1;
                i_in_word <= line_items[0];
            end else begin
                push <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty)
                check_event(o_out_word);
            if ($urandom_range(0, 63) == 0)
                drain_idle_on = !drain_idle_on;
            if (drain_gap == 0 && drain_idle_on && line_items.size() > CALM_TAIL &&
                $urandom_range(0, 7) == 0)
                drain_gap = $urandom_range(1, 12);
            if (drain_gap != 0) begin
                drain_gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    initial begin
        add_item("H", 1'b1, 1'b0);
        add_item("i", 1'b1, 1'b0);
        add_item(CHAR_DASH, 1'b1, 1'b0);
        add_item(CHAR_SPACE, 1'b1, 1'b0);
        add_item(CHAR_SPACE, 1'b1, 1'b0);
        add_item(CHAR_DASH, 1'b1, 1'b0);
        add_item(PUNCT_BYTES[0], 1'b1, 1'b0);
        add_item("Z", 1'b1, 1'b0);
        add_item(PUNCT_BYTES[4], 1'b1, 1'b0);
        add_item(LEAD_FOLD, 1'b1, 1'b0);
        add_item(CAPITAL_TAILS[0], 1'b1, 1'b0);
        add_item(LEAD_FOLD, 1'b1, 1'b0);
        add_item(8'hFF, 1'b1, 1'b0);
        add_item(8'h00, 1'b1, 1'b0);
        add_item(LEAD_SKIP2, 1'b1, 1'b0);
        add_item(8'hA0, 1'b1, 1'b0);
        add_item(8'h0A, 1'b1, 1'b0);
        add_item(LEAD_SKIP3, 1'b1, 1'b0);
        add_item(8'h80, 1'b1, 1'b0);
        add_item(CAPITAL_TAILS[10], 1'b1, 1'b0);
        add_item(PUNCT_BYTES[30], 1'b1, 1'b0);
        add_item(8'h7F, 1'b1, 1'b0);
        add_item(8'hAB, 1'b0, 1'b0);
        add_item(8'h55, 1'b0, 1'b1);
        add_item(LEAD_FOLD, 1'b1, 1'b1);
        add_item(LEAD_SKIP3, 1'b1, 1'b1);
        add_item("a", 1'b1, 1'b1);
        add_item(8'h00, 1'b0, 1'b1);
        while (line_items.size() - ignored_cnt < 28 + RANDOM_ITEMS) begin
            if ($urandom_range(0, 4) != 0)
                add_line();
            else
                add_noise();
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (line_items.size() != 0)
            @(posedge i_clk);
        while (expected_events.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0 && expected_events.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== utf8_word_tokenizer.f =====
+incdir+rtl/core
rtl/core/uwt_pkg.sv
rtl/core/uwt_front.sv
rtl/core/uwt_queue.sv
rtl/core/uwt_back.sv
rtl/core/utf8_word_tokenizer.sv
verif/utf8_word_tokenizer_tb.sv
